FILE: design/bvs_pkg.sv
// Shared types and constants of the bounded vector store.
`default_nettype none
package bvs_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 11;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_SET    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: design/bvs_req_if.sv
// Request channel of the bounded vector store.
`default_nettype none
interface bvs_req_if
    import bvs_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    t_op                        op;
    logic [INDEX_W-1:0]         index;
    logic [COUNT_W-1:0]         count;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, op, index, count, value, input ready);
    modport sink   (input valid, op, index, count, value, output ready);
endinterface
`default_nettype wire

FILE: design/bvs_rsp_if.sv
// Response channel of the bounded vector store.
`default_nettype none
interface bvs_rsp_if
    import bvs_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic signed [VALUE_W-1:0]  read_value;
    logic [LEN_W-1:0]           length;

    modport source (output valid, ok, read_value, length, input ready);
    modport sink   (input valid, ok, read_value, length, output ready);
endinterface
`default_nettype wire

FILE: design/bvs_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
`default_nettype none
module bvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/bounded_vector_store_top.sv
// Top level of the bounded vector store: length register, word RAM and request sequencer.
`default_nettype none
// Bounded vector of signed 32-bit words. The words live in one DEPTH-entry
// RAM (one write port, one read port, registered read) and a length
// register counts the valid entries. Each request is append, remove range,
// get or set, and gives exactly one response carrying ok, the word read (get
// only, zero otherwise) and the length after the request; responses leave in
// request order. One request is in work at a time. Append, set and get go
// from the request cycle in the idle state, where the RAM is written or
// read, to the done state, which hands the response to the output register.
// A remove that moves nothing (empty range, nothing above the range, or a
// rejected range) takes the same path. Any other remove passes through the
// move state between the two, where the RAM streams the tail (the entries
// above the removed range) down one word per cycle, each word read one cycle
// and written back the next, so the single write port sets the pace. A
// response waiting in the output register does not block the next request;
// only a second finished response stalls behind it. RAM contents are
// undefined after reset; only entries below the length can be read and all
// of them have been written, so no clearing pass is needed. The length
// output shows the low eleven bits of the length register.
module bounded_vector_store_top
    import bvs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bvs_req_if.sink    i_req,
    bvs_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    // compare width: holds the length, index + count and DEPTH
    localparam int CW = ((LW > COUNT_W) ? LW : COUNT_W) + 2;

    // sequencer state
    t_state             r_state, n_state;
    logic [LW-1:0]      r_fill, n_fill;
    logic [AW-1:0]      r_src, n_src;       // tail read pointer
    logic [AW-1:0]      r_dst, n_dst;       // tail write pointer
    logic [LW-1:0]      r_rem, n_rem;       // tail words still to read
    logic               r_wr_pend, n_wr_pend;
    logic               r_ok, n_ok;         // response held for the done cycle
    logic               r_rd_get, n_rd_get; // take read data into response

    // output register
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_ok, n_out_ok;
    logic signed [VALUE_W-1:0]  r_out_rd, n_out_rd;
    logic [LW-1:0]              r_out_len, n_out_len;

    // RAM ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic               accept;
    logic [CW-1:0]      idx_e, cnt_e, fill_e, end_e, out_len_e;
    logic               idx_in_range, full, range_ok;

    bvs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // requests taken only when idle and out of reset
    assign i_req.ready = (r_state == S_IDLE) && i_rst_n;
    assign accept      = i_req.valid && i_req.ready;

    assign idx_e  = CW'(i_req.index);
    assign cnt_e  = CW'(i_req.count);
    assign fill_e = CW'(r_fill);
    assign end_e  = idx_e + cnt_e;

    assign idx_in_range = idx_e < fill_e;
    assign full         = (r_fill == LW'(DEPTH));
    assign range_ok     = idx_in_range && (end_e <= fill_e);

    assign out_len_e        = CW'(r_out_len);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_out_ok;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.length     = out_len_e[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_rem     <= n_rem;
        r_ok      <= n_ok;
        r_rd_get  <= n_rd_get;
        r_out_ok  <= n_out_ok;
        r_out_rd  <= n_out_rd;
        r_out_len <= n_out_len;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_src       = r_src;
        n_dst       = r_dst;
        n_rem       = r_rem;
        n_wr_pend   = 1'b0;
        n_ok        = r_ok;
        n_rd_get    = r_rd_get;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_ok    = r_out_ok;
        n_out_rd    = r_out_rd;
        n_out_len   = r_out_len;
        ram_we      = 1'b0;
        ram_waddr   = r_dst;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_src;

        case (r_state)
            S_IDLE: begin
                ram_raddr = AW'(i_req.index);
                if (accept) begin
                    n_rd_get = 1'b0;
                    n_state  = S_DONE;
                    case (i_req.op)
                        OP_APPEND: begin
                            n_ok      = !full;
                            ram_we    = !full;
                            ram_waddr = AW'(r_fill);
                            ram_wdata = i_req.value;
                            if (!full) begin
                                n_fill = r_fill + LW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            n_ok  = range_ok;
                            n_src = AW'(end_e);
                            n_dst = AW'(i_req.index);
                            n_rem = LW'(fill_e - end_e);
                            if (range_ok) begin
                                n_fill = LW'(fill_e - cnt_e);
                                // gap closes only if something sits above it
                                if ((i_req.count != '0) && (end_e != fill_e)) begin
                                    n_state = S_MOVE;
                                end
                            end
                        end
                        OP_GET: begin
                            n_ok     = idx_in_range;
                            n_rd_get = idx_in_range;
                            ram_re   = 1'b1;
                        end
                        OP_SET: begin
                            n_ok      = idx_in_range;
                            ram_we    = idx_in_range;
                            ram_waddr = AW'(i_req.index);
                            ram_wdata = i_req.value;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                // read src this cycle, write its word to dst the next
                ram_we    = r_wr_pend;
                ram_waddr = r_dst;
                ram_wdata = ram_rdata;
                if (r_wr_pend) begin
                    n_dst = r_dst + AW'(1);
                end
                if (r_rem != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_src;
                    n_src     = r_src + AW'(1);
                    n_rem     = r_rem - LW'(1);
                    n_wr_pend = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_rd    = r_rd_get ? ram_rdata : '0;
                    n_out_len   = r_fill;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // length never passes the capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LW'(DEPTH))
        else $error("length register above capacity");

    // a successful append grows the length by one
    a_append_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.op == OP_APPEND) && !full) |=> (r_fill == $past(r_fill) + LW'(1)))
        else $error("append did not grow the length");

    // while streaming the tail, the read pointer stays ahead of the write pointer
    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MOVE) && (r_rem != '0)) |-> (r_src > r_dst))
        else $error("tail move pointers crossed");

    // the RAM is never written while a response is being handed over
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !ram_we)
        else $error("RAM write in response cycle");

    // a rejected request never carries a read word
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ok) |-> (o_rsp.read_value == '0))
        else $error("rejected request returned data");

endmodule
`default_nettype wire
